FILE: design/sdbc_pkg.sv
// Shared constants and types for the swept disc versus box collision pipeline.
`timescale 1ns / 1ps

package sdbc_pkg;

  // Register stages inside each unit, from its input operands to its registered result.
  localparam int CORNER_LAT = 7;
  localparam int SEG_LAT    = 3;

  // Input capture, edge formation, corner unit and final combine.
  localparam int PIPE_LAT = 2 + CORNER_LAT + 1;

  // Side of one box corner relative to the segment's line.
  typedef struct packed {
    logic neg;
    logic pos;
  } sdbc_side_t;

  // Branch decisions of the corner distance test, carried down the pipeline.
  typedef struct packed {
    logic dot_le0;
    logic dot_ge;
    logic near_start;
    logic near_end;
  } sdbc_corner_flags_t;

endpackage

FILE: design/sdbc_seg.sv
// Segment versus axis-aligned box test, three register stages.
`timescale 1ns / 1ps

module sdbc_seg import sdbc_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic signed [CB-1:0] x1,
  input  logic signed [CB-1:0] y1,
  input  logic signed [CB-1:0] x2,
  input  logic signed [CB-1:0] y2,
  input  logic signed [CB+1:0] lx,
  input  logic signed [CB+1:0] ly,
  input  logic signed [CB+1:0] hx,
  input  logic signed [CB+1:0] hy,
  output logic                 hit
);

  localparam int E = CB + 2;
  localparam int D = CB + 1;
  localparam int G = CB + 3;
  localparam int M = D + G;

  logic signed [E-1:0] ex1, ey1, ex2, ey2;
  logic                inside1, sep1;
  logic signed [D-1:0] dx1, dy1;
  logic signed [G-1:0] exl1, exh1, eyl1, eyh1;

  logic                inside2, sep2;
  logic signed [M-1:0] al2, ah2, bl2, bh2;

  sdbc_side_t side [4];
  logic       all_neg, all_pos;

  assign ex1 = E'(x1);
  assign ey1 = E'(y1);
  assign ex2 = E'(x2);
  assign ey2 = E'(y2);

  // Stage 1: endpoint containment, separating-axis reject and operand differences.
  always_ff @(posedge clk) begin
    inside1 <= (lx <= ex1 && ex1 <= hx && ly <= ey1 && ey1 <= hy) ||
               (lx <= ex2 && ex2 <= hx && ly <= ey2 && ey2 <= hy);
    sep1    <= (ex1 < lx && ex2 < lx) || (ex1 > hx && ex2 > hx) ||
               (ey1 < ly && ey2 < ly) || (ey1 > hy && ey2 > hy);
    dx1     <= D'(x2) - D'(x1);
    dy1     <= D'(y2) - D'(y1);
    exl1    <= G'(lx) - G'(x1);
    exh1    <= G'(hx) - G'(x1);
    eyl1    <= G'(ly) - G'(y1);
    eyh1    <= G'(hy) - G'(y1);
  end

  // Stage 2: the four cross products of the side-of-line test.
  always_ff @(posedge clk) begin
    inside2 <= inside1;
    sep2    <= sep1;
    al2     <= M'(dy1) * M'(exl1);
    ah2     <= M'(dy1) * M'(exh1);
    bl2     <= M'(dx1) * M'(eyl1);
    bh2     <= M'(dx1) * M'(eyh1);
  end

  // Corners in order: low-low, high-low, high-high, low-high.
  always_comb begin
    side[0].neg = al2 < bl2;
    side[0].pos = al2 > bl2;
    side[1].neg = ah2 < bl2;
    side[1].pos = ah2 > bl2;
    side[2].neg = ah2 < bh2;
    side[2].pos = ah2 > bh2;
    side[3].neg = al2 < bh2;
    side[3].pos = al2 > bh2;
    all_neg = side[0].neg & side[1].neg & side[2].neg & side[3].neg;
    all_pos = side[0].pos & side[1].pos & side[2].pos & side[3].pos;
  end

  // Stage 3: an endpoint inside, or no axis reject and not all corners strictly on one side.
  always_ff @(posedge clk) begin
    hit <= inside2 | (~sep2 & ~(all_neg | all_pos));
  end

endmodule

FILE: design/sdbc_corner.sv
// Squared distance from one box corner to the segment, compared with the squared radius.
`timescale 1ns / 1ps

module sdbc_corner import sdbc_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic signed [CB-1:0] x1,
  input  logic signed [CB-1:0] y1,
  input  logic signed [CB-1:0] x2,
  input  logic signed [CB-1:0] y2,
  input  logic signed [CB:0]   px,
  input  logic signed [CB:0]   py,
  input  logic        [CB-2:0] r,
  output logic                 near
);

  localparam int D  = CB + 1;
  localparam int X  = CB + 2;
  localparam int PD = 2 * D;
  localparam int PX = D + X;
  localparam int PE = 2 * X;
  localparam int RR = 2 * CB - 2;
  localparam int K  = CB + 1;
  localparam int RH = RR - K;

  logic signed [D-1:0]  dx1, dy1;
  logic signed [X-1:0]  ex1, ey1, fx1, fy1;
  logic        [CB-2:0] r1;

  logic signed [PD-1:0] dxdx2, dydy2;
  logic signed [PX-1:0] dxex2, dyey2, dyex2, dxey2;
  logic signed [PE-1:0] exex2, eyey2, fxfx2, fyfy2;
  logic        [RR-1:0] rr2;

  logic signed [PD:0]   d23;
  logic signed [PX:0]   dot3, t3;
  logic signed [PE:0]   e23, f23;
  logic        [RR-1:0] rr3;

  logic signed [PE:0]   rr3_ext;
  logic        [PX:0]   tmag3;
  sdbc_corner_flags_t   flags3;

  sdbc_corner_flags_t   flags4;
  logic        [K-1:0]  th4, tl4, dh4, dl4, rrl4;
  logic        [RH-1:0] rrh4;

  sdbc_corner_flags_t   flags5;
  logic        [2*K-1:0] tthh5, tthl5, ttll5, rdlh5, rdll5;
  logic        [RH+K-1:0] rdhh5, rdhl5;

  sdbc_corner_flags_t   flags6;
  logic        [4*K-1:0] tt6, rd6;

  // Stage 1: segment direction and corner offsets from both endpoints.
  always_ff @(posedge clk) begin
    dx1 <= D'(x2) - D'(x1);
    dy1 <= D'(y2) - D'(y1);
    ex1 <= X'(px) - X'(x1);
    ey1 <= X'(py) - X'(y1);
    fx1 <= X'(px) - X'(x2);
    fy1 <= X'(py) - X'(y2);
    r1  <= r;
  end

  // Stage 2: all products, one multiplier each.
  always_ff @(posedge clk) begin
    dxdx2 <= PD'(dx1) * PD'(dx1);
    dydy2 <= PD'(dy1) * PD'(dy1);
    dxex2 <= PX'(dx1) * PX'(ex1);
    dyey2 <= PX'(dy1) * PX'(ey1);
    dyex2 <= PX'(dy1) * PX'(ex1);
    dxey2 <= PX'(dx1) * PX'(ey1);
    exex2 <= PE'(ex1) * PE'(ex1);
    eyey2 <= PE'(ey1) * PE'(ey1);
    fxfx2 <= PE'(fx1) * PE'(fx1);
    fyfy2 <= PE'(fy1) * PE'(fy1);
    rr2   <= RR'(r1) * RR'(r1);
  end

  // Stage 3: squared length, projection, endpoint distances and the cross term.
  always_ff @(posedge clk) begin
    d23  <= (PD+1)'(dxdx2) + (PD+1)'(dydy2);
    dot3 <= (PX+1)'(dxex2) + (PX+1)'(dyey2);
    t3   <= (PX+1)'(dyex2) - (PX+1)'(dxey2);
    e23  <= (PE+1)'(exex2) + (PE+1)'(eyey2);
    f23  <= (PE+1)'(fxfx2) + (PE+1)'(fyfy2);
    rr3  <= rr2;
  end

  always_comb begin
    rr3_ext           = (PE+1)'($signed({1'b0, rr3}));
    tmag3             = t3[PX] ? (PX+1)'(-t3) : (PX+1)'(t3);
    flags3.dot_le0    = dot3[PX] | (dot3 == '0);
    flags3.dot_ge     = (PX+2)'(dot3) >= (PX+2)'(d23);
    flags3.near_start = e23 < rr3_ext;
    flags3.near_end   = f23 < rr3_ext;
  end

  // Stage 4: branch flags and the wide operands split into halves.
  always_ff @(posedge clk) begin
    flags4 <= flags3;
    th4    <= tmag3[2*K-1:K];
    tl4    <= tmag3[K-1:0];
    dh4    <= d23[2*K-1:K];
    dl4    <= d23[K-1:0];
    rrh4   <= rr3[RR-1:K];
    rrl4   <= rr3[K-1:0];
  end

  // Stage 5: partial products of t*t and rr*d2.
  always_ff @(posedge clk) begin
    flags5 <= flags4;
    tthh5  <= (2*K)'(th4) * (2*K)'(th4);
    tthl5  <= (2*K)'(th4) * (2*K)'(tl4);
    ttll5  <= (2*K)'(tl4) * (2*K)'(tl4);
    rdhh5  <= (RH+K)'(rrh4) * (RH+K)'(dh4);
    rdhl5  <= (RH+K)'(rrh4) * (RH+K)'(dl4);
    rdlh5  <= (2*K)'(rrl4) * (2*K)'(dh4);
    rdll5  <= (2*K)'(rrl4) * (2*K)'(dl4);
  end

  // Stage 6: partial products summed into the full squares.
  always_ff @(posedge clk) begin
    flags6 <= flags5;
    tt6    <= {tthh5, ttll5} + ((4*K)'(tthl5) << (K + 1));
    rd6    <= {(2*K)'(rdhh5), rdll5} + (((4*K)'(rdhl5) + (4*K)'(rdlh5)) << K);
  end

  // Stage 7: pick the branch that the projection falls into.
  always_ff @(posedge clk) begin
    if (flags6.dot_le0) begin
      near <= flags6.near_start;
    end else if (flags6.dot_ge) begin
      near <= flags6.near_end;
    end else begin
      near <= tt6 < rd6;
    end
  end

endmodule

FILE: design/swept_disc_box_collision.sv
// Top level of the swept disc versus axis-aligned box collision pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Transfer when            Ports
// query     in         start high, busy low     box_x box_y box_width box_height
//                                                start_x start_y end_x end_y disc_radius
// result    out        done high (one cycle)    hit
//
// A query passes through input capture, edge formation, the corner units and the final combine;
// the latency is set by the corner distance unit, whose wide t*t and rr*d2 products
// are split into partial products over three stages. One query is taken every cycle.
// busy is held low: the pipeline never stalls, because the receiver cannot refuse a
// result. Reset clears only the valid bits; data registers are left as they are.

module swept_disc_box_collision import sdbc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-2:0] box_width,
  input  logic [COORD_BITS-2:0] box_height,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-2:0] disc_radius,
  output logic                  done,
  output logic                  hit
);

  localparam int C   = COORD_BITS;
  localparam int P   = C + 1;
  localparam int E   = C + 2;
  localparam int DLY = CORNER_LAT - SEG_LAT;

  logic [PIPE_LAT-1:0] vld;

  // Captured query.
  logic signed [C-1:0] a_bx, a_by, a_x1, a_y1, a_x2, a_y2;
  logic        [C-2:0] a_w, a_h, a_r;

  // Box corners, widened boxes and pass-through segment.
  logic signed [C-1:0] b_x1, b_y1, b_x2, b_y2;
  logic signed [P-1:0] b_cx0, b_cx1, b_cy0, b_cy1;
  logic signed [E-1:0] b_wlx, b_whx, b_wly, b_why;
  logic        [C-2:0] b_r;

  logic signed [E-1:0] b_lx, b_hx, b_ly, b_hy;

  logic       seg_x_hit, seg_y_hit;
  logic [1:0] seg_dly [DLY];
  logic [3:0] near;
  logic       hit_q;

  // The pipeline always has room, so a query is taken whenever start is high.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    a_bx <= $signed(box_x);
    a_by <= $signed(box_y);
    a_w  <= box_width;
    a_h  <= box_height;
    a_x1 <= $signed(start_x);
    a_y1 <= $signed(start_y);
    a_x2 <= $signed(end_x);
    a_y2 <= $signed(end_y);
    a_r  <= disc_radius;
  end

  // Corners use one extra bit for the far edges; the boxes widened by the radius
  // need two.
  always_ff @(posedge clk) begin
    b_x1  <= a_x1;
    b_y1  <= a_y1;
    b_x2  <= a_x2;
    b_y2  <= a_y2;
    b_r   <= a_r;
    b_cx0 <= P'(a_bx);
    b_cy0 <= P'(a_by);
    b_cx1 <= P'(a_bx) + $signed({2'b00, a_w});
    b_cy1 <= P'(a_by) + $signed({2'b00, a_h});
    b_wlx <= E'(a_bx) - $signed({3'b000, a_r});
    b_wly <= E'(a_by) - $signed({3'b000, a_r});
    b_whx <= E'(a_bx) + $signed({3'b000, a_w}) + $signed({3'b000, a_r});
    b_why <= E'(a_by) + $signed({3'b000, a_h}) + $signed({3'b000, a_r});
  end

  assign b_lx = E'(b_cx0);
  assign b_hx = E'(b_cx1);
  assign b_ly = E'(b_cy0);
  assign b_hy = E'(b_cy1);

  // Box stretched sideways by the radius.
  sdbc_seg #(.CB(C)) u_seg_x (
    .clk (clk),
    .x1  (b_x1),
    .y1  (b_y1),
    .x2  (b_x2),
    .y2  (b_y2),
    .lx  (b_wlx),
    .ly  (b_ly),
    .hx  (b_whx),
    .hy  (b_hy),
    .hit (seg_x_hit)
  );

  // Box stretched vertically by the radius.
  sdbc_seg #(.CB(C)) u_seg_y (
    .clk (clk),
    .x1  (b_x1),
    .y1  (b_y1),
    .x2  (b_x2),
    .y2  (b_y2),
    .lx  (b_lx),
    .ly  (b_wly),
    .hx  (b_hx),
    .hy  (b_why),
    .hit (seg_y_hit)
  );

  // The rounded corners of the swept shape, one unit per box corner.
  sdbc_corner #(.CB(C)) u_corner_ll (
    .clk (clk), .x1 (b_x1), .y1 (b_y1), .x2 (b_x2), .y2 (b_y2),
    .px (b_cx0), .py (b_cy0), .r (b_r), .near (near[0])
  );

  sdbc_corner #(.CB(C)) u_corner_hl (
    .clk (clk), .x1 (b_x1), .y1 (b_y1), .x2 (b_x2), .y2 (b_y2),
    .px (b_cx1), .py (b_cy0), .r (b_r), .near (near[1])
  );

  sdbc_corner #(.CB(C)) u_corner_hh (
    .clk (clk), .x1 (b_x1), .y1 (b_y1), .x2 (b_x2), .y2 (b_y2),
    .px (b_cx1), .py (b_cy1), .r (b_r), .near (near[2])
  );

  sdbc_corner #(.CB(C)) u_corner_lh (
    .clk (clk), .x1 (b_x1), .y1 (b_y1), .x2 (b_x2), .y2 (b_y2),
    .px (b_cx0), .py (b_cy1), .r (b_r), .near (near[3])
  );

  // The segment tests finish early; hold them until the corner results arrive.
  always_ff @(posedge clk) begin
    seg_dly[0] <= {seg_y_hit, seg_x_hit};
    for (int i = 1; i < DLY; i++) begin
      seg_dly[i] <= seg_dly[i-1];
    end
  end

  always_ff @(posedge clk) begin
    hit_q <= (|near) | (|seg_dly[DLY-1]);
  end

  assign done = vld[PIPE_LAT-1];
  assign hit  = hit_q & done;

  // Every accepted query yields its result strobe.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted query produced no result in time");

  // No result appears without a matching accepted query.
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching query");

  // The hit flag is only raised together with the result strobe.
  a_hit_gated : assert property (@(posedge clk) disable iff (rst)
    !done |-> !hit)
    else $error("hit raised outside a result cycle");

endmodule

FILE: test/tb_swept_disc_box_collision.sv
// Self-checking testbench for the swept disc versus box collision pipeline.
`timescale 1ns / 1ps

module tb_swept_disc_box_collision import sdbc_pkg::*;;

  localparam int CB = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // One collision query as it crosses the query channel.
  typedef struct {
    logic signed [CB-1:0] bx, by;
    logic [CB-2:0] w, h;
    logic signed [CB-1:0] x1, y1, x2, y2;
    logic [CB-2:0] r;
  } query_t;

  // Keeps the expected hit flags in transfer order and checks results against them.
  class hit_scoreboard;
    bit expected_hits[$];
    int errors;

    // Every product below fits easily in 160 bits, so nothing wraps.
    static function bit in_box(longint px, longint py, longint lx, longint ly,
                               longint hx, longint hy);
      return lx <= px && px <= hx && ly <= py && py <= hy;
    endfunction

    static function int line_side(longint px, longint py, longint x1, longint y1,
                                  longint x2, longint y2);
      logic signed [159:0] a, b;
      a = 160'(y2 - y1) * 160'(px - x1);
      b = 160'(x2 - x1) * 160'(py - y1);
      return (a < b) ? -1 : (a > b) ? 1 : 0;
    endfunction

    static function bit crosses_box(longint x1, longint y1, longint x2, longint y2,
                                    longint lx, longint ly, longint hx, longint hy);
      int s[4];
      int neg, pos;
      if (in_box(x1, y1, lx, ly, hx, hy) || in_box(x2, y2, lx, ly, hx, hy)) return 1'b1;
      if ((x1 < lx && x2 < lx) || (x1 > hx && x2 > hx) ||
          (y1 < ly && y2 < ly) || (y1 > hy && y2 > hy)) return 1'b0;
      s[0] = line_side(lx, ly, x1, y1, x2, y2);
      s[1] = line_side(hx, ly, x1, y1, x2, y2);
      s[2] = line_side(hx, hy, x1, y1, x2, y2);
      s[3] = line_side(lx, hy, x1, y1, x2, y2);
      neg = 0;
      pos = 0;
      foreach (s[i]) begin
        if (s[i] < 0) neg++;
        if (s[i] > 0) pos++;
      end
      return !(neg == 4 || pos == 4);
    endfunction

    // Squared distance from a corner to the segment, compared against r squared.
    static function bit corner_close(longint x1, longint y1, longint x2, longint y2,
                                     longint px, longint py, longint r);
      logic signed [159:0] dx, dy, ex, ey, rr, d2, dot, t, fx, fy;
      dx = 160'(x2 - x1);  dy = 160'(y2 - y1);
      ex = 160'(px - x1);  ey = 160'(py - y1);
      fx = 160'(px - x2);  fy = 160'(py - y2);
      rr = 160'(r) * 160'(r);
      d2 = dx * dx + dy * dy;
      dot = dx * ex + dy * ey;
      if (dot <= 0) return (ex * ex + ey * ey) < rr;
      if (dot >= d2) return (fx * fx + fy * fy) < rr;
      t = dy * ex - dx * ey;
      return (t * t) < (rr * d2);
    endfunction

    static function bit swept_hit(query_t q);
      longint bx, by, w, h, r, x1, y1, x2, y2;
      bx = longint'(q.bx);  by = longint'(q.by);
      w = longint'(q.w);  h = longint'(q.h);  r = longint'(q.r);
      x1 = longint'(q.x1);  y1 = longint'(q.y1);
      x2 = longint'(q.x2);  y2 = longint'(q.y2);
      return crosses_box(x1, y1, x2, y2, bx - r, by, bx + w + r, by + h) ||
             crosses_box(x1, y1, x2, y2, bx, by - r, bx + w, by + h + r) ||
             corner_close(x1, y1, x2, y2, bx, by, r) ||
             corner_close(x1, y1, x2, y2, bx + w, by, r) ||
             corner_close(x1, y1, x2, y2, bx + w, by + h, r) ||
             corner_close(x1, y1, x2, y2, bx, by + h, r);
    endfunction

    function void note_query(query_t q);
      expected_hits.push_back(swept_hit(q));
    endfunction

    function void check_hit(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        $error("unexpected result: hit=%0b with no query outstanding", got);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (got !== want) begin
        $error("mismatch on hit: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, hit;
  logic [CB-1:0] box_x = '0, box_y = '0, start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [CB-2:0] box_width = '0, box_height = '0, disc_radius = '0;

  hit_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  always #5 clk = ~clk;

  swept_disc_box_collision #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .disc_radius(disc_radius), .done(done), .hit(hit)
  );

  // Results cannot be held off, so each done cycle is checked at the edge that ends it.
  // The watchdog counts edges with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_hit(hit);
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_swept_disc_box_collision failed");
      $finish;
    end
  end

  // Offers one query, with a random number of idle cycles first according to
  // idle_pct, and returns after the edge at which it transfers. start stays high
  // across back-to-back transfers, so it is never lowered and raised in one step.
  task automatic send_query(query_t q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    box_x <= q.bx;  box_y <= q.by;
    box_width <= q.w;  box_height <= q.h;
    start_x <= q.x1;  start_y <= q.y1;
    end_x <= q.x2;  end_y <= q.y2;
    disc_radius <= q.r;
    do @(posedge clk); while (busy);
    sb.note_query(q);
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic query_t make_query(int bx, int by, int w, int h, int x1, int y1,
                                        int x2, int y2, int r);
    query_t q;
    q.bx = CB'(bx);  q.by = CB'(by);  q.w = (CB-1)'(w);  q.h = (CB-1)'(h);
    q.x1 = CB'(x1);  q.y1 = CB'(y1);  q.x2 = CB'(x2);  q.y2 = CB'(y2);
    q.r = (CB-1)'(r);
    return q;
  endfunction

  // Coordinates mostly within a few boxes of each other so hits and misses both
  // occur often; now and then the full field range is used.
  function automatic query_t random_query();
    query_t q;
    int span;
    if ($urandom_range(9) == 0) begin
      q.bx = CB'($urandom);  q.by = CB'($urandom);
      q.w = (CB-1)'($urandom);  q.h = (CB-1)'($urandom);
      q.x1 = CB'($urandom);  q.y1 = CB'($urandom);
      q.x2 = CB'($urandom);  q.y2 = CB'($urandom);
      q.r = (CB-1)'($urandom);
      return q;
    end
    span = 1 << $urandom_range(4, 12);
    q.bx = CB'($urandom_range(0, 2 * span) - span);
    q.by = CB'($urandom_range(0, 2 * span) - span);
    q.w = (CB-1)'($urandom_range(0, span));
    q.h = (CB-1)'($urandom_range(0, span));
    q.x1 = CB'($urandom_range(0, 4 * span) - 2 * span);
    q.y1 = CB'($urandom_range(0, 4 * span) - 2 * span);
    if ($urandom_range(9) == 0) begin
      // Degenerate segment: the sweep collapses to a single point.
      q.x2 = q.x1;
      q.y2 = q.y1;
    end else begin
      q.x2 = CB'($urandom_range(0, 4 * span) - 2 * span);
      q.y2 = CB'($urandom_range(0, 4 * span) - 2 * span);
    end
    q.r = ($urandom_range(7) == 0) ? '0 : (CB-1)'($urandom_range(0, span / 2));
    return q;
  endfunction

  initial begin
    query_t q;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed queries: field extremes, a degenerate segment, a zero radius,
    // corner projections before the start and beyond the end, and both
    // segment-versus-box outcomes.
    send_query(make_query(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768,
                          32767));
    send_query(make_query(32767, 32767, 0, 0, -32768, -32768, -32768, -32768, 0));
    send_query(make_query(0, 0, 160, 160, 80, 80, 80, 80, 0));
    send_query(make_query(0, 0, 160, 160, 200, 80, 200, 80, 40));
    send_query(make_query(0, 0, 160, 160, 200, 80, 200, 80, 41));
    send_query(make_query(0, 0, 160, 160, 190, 190, 190, 190, 40));
    send_query(make_query(0, 0, 160, 160, 190, 190, 190, 190, 50));
    send_query(make_query(0, 0, 160, 160, -100, 200, 300, 200, 0));
    send_query(make_query(0, 0, 160, 160, -100, 200, 300, 200, 40));
    send_query(make_query(0, 0, 160, 160, -100, 200, 300, 200, 39));
    send_query(make_query(0, 0, 160, 160, -100, -100, 300, 300, 0));
    send_query(make_query(0, 0, 160, 160, 200, 200, 400, 400, 50));
    send_query(make_query(0, 0, 160, 160, -400, -400, -200, -200, 50));
    send_query(make_query(0, 0, 160, 160, 160, 160, 400, 400, 0));
    send_query(make_query(0, 0, 160, 160, 161, 0, 161, 160, 0));
    send_query(make_query(0, 0, 160, 160, 161, 0, 161, 160, 1));
    send_query(make_query(0, 0, 0, 0, -10, 10, 10, -10, 0));
    send_query(make_query(0, 0, 0, 0, -10, 11, 10, -10, 0));
    send_query(make_query(-32768, 32767, 32767, 0, 32767, -32768, -32768, 32767, 0));
    send_query(make_query(0, 0, 16383, 21845, 21845, 10922, -21846, -10923, 10922));

    // Hold off until every directed result is back before the random phases.
    go_quiet();
    while (sb.expected_hits.size() != 0) @(posedge clk);

    // Random phases: no idling, heavy idling, moderate idling, then none again.
    idle_pct = 0;
    repeat (200) send_query(random_query());
    idle_pct = 79;
    repeat (150) send_query(random_query());
    idle_pct = 25;
    repeat (150) send_query(random_query());
    idle_pct = 0;
    repeat (150) send_query(random_query());
    go_quiet();

    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_swept_disc_box_collision passed");
    end else begin
      $display("tb_swept_disc_box_collision failed");
    end
    $finish;
  end
endmodule

FILE: files.f
design/sdbc_pkg.sv
design/sdbc_seg.sv
design/sdbc_corner.sv
design/swept_disc_box_collision.sv
test/tb_swept_disc_box_collision.sv
